FILE: design/twm_pkg.sv
// Package for the trimmed-window pH meter: fixed field widths, scale constants
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package twm_pkg;

	localparam int CFG_W     = 12;
	localparam int TRIM_W    = 16;
	localparam int MEAN_W    = 18;
	localparam int MV_W      = 13;
	localparam int PH_W      = 16;
	localparam int FRAC_BITS = 8;
	localparam int MV_SCALE  = 5000;   // millivolts at full scale
	localparam int PH_SCALE  = 17500;  // milli-pH at full scale (3.5 pH/V * 5 V)

	typedef struct packed {
		logic write;     // store accepted sample, restart the scan
		logic rd_en;     // read one window entry
		logic trim;      // form sum minus min and max
		logic mul;       // load the divider lanes
		logic div_step;  // reciprocal multiply on every lane
		logic out_load;  // capture the result fields
	} twm_cmd_t;

	typedef struct packed {
		logic scan_last;
	} twm_status_t;

endpackage

`default_nettype wire

FILE: design/twm_sample_if.sv
// Valid/ready channel carrying one ADC sample per transaction.
// No dependencies.
`default_nettype none

interface twm_sample_if #(
	parameter int SAMPLE_W = 10
);
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

FILE: design/twm_result_if.sv
// Valid/ready channel carrying one meter result per transaction.
// Depends on twm_pkg for the field widths.
`default_nettype none

interface twm_result_if;
	import twm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [TRIM_W-1:0]        trimmed_sum;
	logic [MEAN_W-1:0]        mean_q8;
	logic [MV_W-1:0]          voltage_mv;
	logic signed [PH_W-1:0]   ph_milli;

	modport source (output valid, output trimmed_sum, output mean_q8, output voltage_mv,
		output ph_milli, input ready);
	modport sink   (input valid, input trimmed_sum, input mean_q8, input voltage_mv,
		input ph_milli, output ready);
endinterface

`default_nettype wire

FILE: design/twm_ctrl.sv
// Controller of the trimmed-window pH meter: sequences write, scan, trim,
// scale, divide and output. Depends on twm_pkg.
`default_nettype none

module twm_ctrl import twm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire twm_status_t status,
	output twm_cmd_t         cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_DRAIN = 7'b0000100,
		S_TRIM  = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_vld_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.write = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (status.scan_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_TRIM;
			S_TRIM: begin
				cmd.trim = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_vld_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: design/twm_dp.sv
// Datapath of the trimmed-window pH meter: sample window memory, scan
// accumulator, constant scaling and three reciprocal multipliers that divide
// by WINDOW-2. Depends on twm_pkg.
`default_nettype none

module twm_dp import twm_pkg::*; #(
	parameter int WINDOW   = 40,
	parameter int ADC_BITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire twm_cmd_t              cmd,
	output twm_status_t                status,
	input  wire logic [ADC_BITS-1:0]   adc_sample,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	output logic [TRIM_W-1:0]          trimmed_sum,
	output logic [MEAN_W-1:0]          mean_q8,
	output logic [MV_W-1:0]            voltage_mv,
	output logic signed [PH_W-1:0]     ph_milli
);

	localparam int IDX_W   = $clog2(WINDOW);
	localparam int SUM_W   = ADC_BITS + $clog2(WINDOW);
	localparam int MEAN_DW = SUM_W + FRAC_BITS;
	localparam int SCL_DW  = SUM_W + 15 - ADC_BITS;
	localparam int DIV_W   = (MEAN_DW > SCL_DW) ? MEAN_DW : SCL_DW;
	localparam int TX_W    = (SUM_W > TRIM_W) ? SUM_W : TRIM_W;
	localparam int LANES   = 3;
	// ceil(2^RCP_SH / (WINDOW-2)) gives the exact floor for any DIV_W-bit dividend
	localparam int RCP_SH  = DIV_W + $clog2(WINDOW - 2);
	localparam int RCP_W   = DIV_W + 2;
	localparam int PROD_W  = DIV_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << RCP_SH) + 64'(WINDOW - 3)) / 64'(WINDOW - 2));

	// lane order: mean, voltage, pH
	localparam int L_MEAN = 0;
	localparam int L_MV   = 1;
	localparam int L_PH   = 2;

	logic [ADC_BITS-1:0] mem [WINDOW];
	logic [WINDOW-1:0]   vld_q;
	logic [IDX_W-1:0]    wr_idx_q;
	logic [IDX_W-1:0]    rd_addr_q;
	logic [ADC_BITS-1:0] rd_data_s1;
	logic                rd_vld_s1;
	logic                rd_en_s1;
	logic [ADC_BITS-1:0] entry;
	logic [SUM_W-1:0]    sum_q;
	logic [ADC_BITS-1:0] min_q, max_q;
	logic [SUM_W-1:0]    trim_q;
	logic [CFG_W-1:0]    offset_q;
	logic [DIV_W-1:0]    quo_q [LANES];
	logic [SUM_W+12:0]   mul_mv;
	logic [SUM_W+14:0]   mul_ph;
	logic [TX_W-1:0]     trim_ext;
	logic [PH_W-1:0]     ph_sum;

	assign status.scan_last = (rd_addr_q == IDX_W'(WINDOW - 1));

	// never-written entries read as zero
	assign entry = rd_vld_s1 ? rd_data_s1 : '0;

	assign mul_mv   = {13'd0, trim_q} * (SUM_W + 13)'(MV_SCALE);
	assign mul_ph   = {15'd0, trim_q} * (SUM_W + 15)'(PH_SCALE);
	assign trim_ext = TX_W'(trim_q);
	assign ph_sum   = quo_q[L_PH][PH_W-1:0] + {{(PH_W-CFG_W){offset_q[CFG_W-1]}}, offset_q};

	always_ff @(posedge clk) begin
		if (cmd.write)
			mem[wr_idx_q] <= adc_sample;
		if (cmd.rd_en)
			rd_data_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			wr_idx_q  <= '0;
			rd_addr_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_en_s1  <= 1'b0;
			offset_q  <= '0;
		end else begin
			rd_en_s1 <= cmd.rd_en;
			if (cfg_we)
				offset_q <= cfg_wdata;
			if (cmd.write) begin
				vld_q[wr_idx_q] <= 1'b1;
				wr_idx_q  <= (wr_idx_q == IDX_W'(WINDOW - 1)) ? '0 : wr_idx_q + 1'b1;
				rd_addr_q <= '0;
			end else if (cmd.rd_en) begin
				rd_addr_q <= rd_addr_q + 1'b1;
			end
			if (cmd.rd_en)
				rd_vld_s1 <= vld_q[rd_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
		end else if (rd_en_s1) begin
			sum_q <= sum_q + SUM_W'(entry);
			if (entry < min_q)
				min_q <= entry;
			if (entry > max_q)
				max_q <= entry;
		end
		if (cmd.trim)
			trim_q <= sum_q - SUM_W'(min_q) - SUM_W'(max_q);
	end

	// divide by the scaled 2^ADC_BITS first, then by WINDOW-2: same floor
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			quo_q[L_MEAN] <= DIV_W'({trim_q, {FRAC_BITS{1'b0}}});
			quo_q[L_MV]   <= DIV_W'(mul_mv >> ADC_BITS);
			quo_q[L_PH]   <= DIV_W'(mul_ph >> ADC_BITS);
		end else if (cmd.div_step) begin
			for (int l = 0; l < LANES; l++)
				quo_q[l] <= DIV_W'((PROD_W'(quo_q[l]) * PROD_W'(RECIP)) >> RCP_SH);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			trimmed_sum <= trim_ext[TRIM_W-1:0];
			mean_q8     <= quo_q[L_MEAN][MEAN_W-1:0];
			voltage_mv  <= quo_q[L_MV][MV_W-1:0];
			ph_milli    <= ph_sum;
		end
	end

endmodule

`default_nettype wire

FILE: design/trimmed_window_ph_meter.sv
// Trimmed-window pH meter. Each sample transaction writes one ADC reading into
// a ring window of WINDOW entries (zero after reset), then the block walks the
// whole window one entry per cycle to find the sum, minimum and maximum, drops
// one minimum and one maximum, and returns the trimmed sum, the mean in counts
// with 8 fraction bits, the probe voltage in mV and the pH in milli-pH plus the
// signed offset register. A new sample is accepted only once the last one is
// through. After the walk a drain state lets the last read land, then the block
// trims, scales by the constants, divides by WINDOW-2 through a reciprocal
// multiply and loads the output once the output register is free. A finished
// result waits in the output register while the next sample is taken. The user
// must write the offset through cfg_we/cfg_wdata only while idle; the block
// itself does not enforce it.
// Depends on twm_pkg, twm_sample_if, twm_result_if, twm_ctrl and twm_dp.
`default_nettype none

module trimmed_window_ph_meter import twm_pkg::*; #(
	parameter int WINDOW   = 40,
	parameter int ADC_BITS = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	twm_sample_if.sink            sample,
	twm_result_if.source          result,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	twm_cmd_t    cmd;
	twm_status_t status;

	twm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	twm_dp #(
		.WINDOW   (WINDOW),
		.ADC_BITS (ADC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.adc_sample  (sample.adc_sample),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.trimmed_sum (result.trimmed_sum),
		.mean_q8     (result.mean_q8),
		.voltage_mv  (result.voltage_mv),
		.ph_milli    (result.ph_milli)
	);

endmodule

`default_nettype wire
